// ----- rtl/ffsa_pkg.sv -----
// Shared types and codes for the FIFO free-list slot allocator.
package ffsa_pkg;

  // Width of the slot number carried on the ports
  localparam int unsigned SLOT_W = 5;

  // Request mode codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_DONE        = 2'd0,
    STATUS_NO_FREE     = 2'd1,
    STATUS_NOT_IN_USE  = 2'd2
  } status_t;

  // Request payload
  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
  } req_t;

  // Result payload
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] granted_slot;
    status_t           status;
  } rsp_t;

endpackage

// ----- rtl/ffsa_ring.sv -----
// Free-slot ring memory with a fill counter that stands in for the reset contents.
module ffsa_ring #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IW    = 5,
  parameter int unsigned CW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] rd_addr,
  output logic [IW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [IW-1:0] wr_data
);

  logic [IW-1:0] mem_r [DEPTH];
  logic [IW-1:0] rd_mem_r;
  logic [IW-1:0] rd_addr_r;
  logic          rd_written_r;
  logic [CW-1:0] fill_r;

  // Writes land in index order from entry 0, so entries below fill_r are written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr_en && (fill_r != CW'(DEPTH))) begin
      fill_r <= fill_r + CW'(1);
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read; remember whether the entry was ever written
  always_ff @(posedge clk) begin
    rd_mem_r     <= mem_r[rd_addr];
    rd_addr_r    <= rd_addr;
    rd_written_r <= (CW'(rd_addr) < fill_r);
  end

  // An unwritten entry still holds its reset value, its own index
  assign rd_data = rd_written_r ? rd_mem_r : rd_addr_r;

endmodule

// ----- rtl/fifo_free_list_slot_allocator.sv -----
// Top level of the FIFO free-list slot allocator.
//
//   Channel | Ports                          | Payload
//   --------+--------------------------------+--------------------------------
//   request | in_valid, in_ready, in_data    | ffsa_pkg::req_t  (mode, slot)
//   result  | out_valid, out_ready, out_data | ffsa_pkg::rsp_t  (ok, slot, status)
//
// Each request first reads the ring entry at the head pointer from the synchronous
// ring memory, then decides and writes back.
// A new request is taken while the previous result still sits in the output register.
// If the output register is still full, the decision cycle stalls until it is taken.
// Reset is synchronous and takes effect at once; no clearing pass is needed.
module fifo_free_list_slot_allocator #(
  parameter int unsigned POOL_SIZE = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffsa_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ffsa_pkg::rsp_t out_data
);

  localparam int unsigned IW = $clog2(POOL_SIZE);
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                 state_r;
  ffsa_pkg::req_t         req_r;
  logic [IW-1:0]          head_r;
  logic [CW-1:0]          count_r;
  logic [POOL_SIZE-1:0]   in_use_r;
  logic                   out_valid_r;
  ffsa_pkg::rsp_t         out_data_r;

  logic [IW-1:0]          ring_rd_data;
  logic                   ring_wr_en;
  logic [IW-1:0]          tail;
  logic [IW:0]            tail_sum;
  logic [31:0]            slot_w;
  logic [IW-1:0]          slot_idx;
  logic [31:0]            grant_w;
  logic                   finish;
  logic                   alloc_ok;
  logic                   free_ok;
  ffsa_pkg::rsp_t         rsp;

  // Ring of free slot numbers
  ffsa_ring #(
    .DEPTH (POOL_SIZE),
    .IW    (IW),
    .CW    (CW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (head_r),
    .rd_data (ring_rd_data),
    .wr_en   (ring_wr_en),
    .wr_addr (tail),
    .wr_data (slot_idx)
  );

  // Tail index: head plus count, wrapped once
  always_comb begin
    tail_sum = {1'b0, head_r} + (IW+1)'(count_r);
    if (tail_sum >= (IW+1)'(POOL_SIZE)) begin
      tail = IW'(tail_sum - (IW+1)'(POOL_SIZE));
    end else begin
      tail = IW'(tail_sum);
    end
  end

  // Decide the request held in req_r
  always_comb begin
    slot_w   = 32'(req_r.slot);
    slot_idx = slot_w[IW-1:0];
    grant_w  = 32'(ring_rd_data);
    alloc_ok = (count_r != '0);
    free_ok  = (slot_w < 32'(POOL_SIZE)) && in_use_r[slot_idx] &&
               (count_r != CW'(POOL_SIZE));
    rsp      = '0;
    if (req_r.mode == ffsa_pkg::MODE_ALLOC) begin
      if (alloc_ok) begin
        rsp.ok           = 1'b1;
        rsp.granted_slot = grant_w[ffsa_pkg::SLOT_W-1:0];
        rsp.status       = ffsa_pkg::STATUS_DONE;
      end else begin
        rsp.status       = ffsa_pkg::STATUS_NO_FREE;
      end
    end else begin
      if (free_ok) begin
        rsp.ok     = 1'b1;
        rsp.status = ffsa_pkg::STATUS_DONE;
      end else begin
        rsp.status = ffsa_pkg::STATUS_NOT_IN_USE;
      end
    end
  end

  assign finish     = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign ring_wr_en = finish && (req_r.mode == ffsa_pkg::MODE_FREE) && free_ok;
  assign in_ready   = (state_r == ST_IDLE);

  // Sequencer, pool state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= CW'(POOL_SIZE);
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a finished request, drop it once transferred
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (finish) begin
            out_data_r  <= rsp;
            state_r     <= ST_IDLE;
            if (req_r.mode == ffsa_pkg::MODE_ALLOC) begin
              if (alloc_ok) begin
                in_use_r[ring_rd_data] <= 1'b1;
                head_r  <= (head_r == IW'(POOL_SIZE - 1)) ? '0 : head_r + IW'(1);
                count_r <= count_r - CW'(1);
              end
            end else if (free_ok) begin
              in_use_r[slot_idx] <= 1'b0;
              count_r <= count_r + CW'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
